// ----- src/rsbk_pkg.sv -----
// Package for record_sort_by_key: record and queue entry types, stream packing helpers.
// No dependencies; used by every module of the block.
package rsbk_pkg;

   // Stream data width: 215 bits of record packed from bit 0, padded to whole bytes
   localparam int unsigned TDATA_W = 216;

   // Depth of the queue between front and back; must be a power of two
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = 2;
   localparam int unsigned QCNT_W      = 3;

   typedef struct packed {
      logic [30:0]        roll_number;
      logic [63:0]        name_high;
      logic [63:0]        name_mid;
      logic [31:0]        name_low;
      logic signed [23:0] mark_key;
   } record_type;

   // One classified transaction as the front hands it to the back
   typedef struct packed {
      record_type rec;
      logic       group_end;
      logic       drop;      // group already full: record is discarded
   } queue_entry_type;

   typedef enum logic [0:0] {
      ST_LOAD  = 1'b0,
      ST_DRAIN = 1'b1
   } back_state_type;

   // tdata, lowest bit up: roll_number, name_high, name_mid, name_low, mark_key, pad
   function automatic record_type unpack_record(input logic [TDATA_W-1:0] data);
      record_type r;
      r.roll_number = data[30:0];
      r.name_high   = data[94:31];
      r.name_mid    = data[158:95];
      r.name_low    = data[190:159];
      r.mark_key    = data[214:191];
      return r;
   endfunction

   function automatic logic [TDATA_W-1:0] pack_record(input record_type r);
      return {1'b0, r.mark_key, r.name_low, r.name_mid, r.name_high, r.roll_number};
   endfunction

endpackage

// ----- src/rsbk_queue.sv -----
// Short FIFO of classified records between the front and the back.
// Depends on rsbk_pkg for the entry type and depth constants.
module rsbk_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  rsbk_pkg::queue_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output logic                     head_valid,
   output rsbk_pkg::queue_entry_type head_entry
);

   rsbk_pkg::queue_entry_type mem_ff [rsbk_pkg::QUEUE_DEPTH];
   logic [rsbk_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rsbk_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rsbk_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_push, do_pop;

   assign full       = (count_ff == rsbk_pkg::QCNT_W'(rsbk_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and occupancy update; pointers wrap as the depth is a power of two
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- src/rsbk_front.sv -----
// Front of record_sort_by_key: accepts input transactions and marks records beyond capacity.
// Depends on rsbk_pkg for the record and queue entry types.
module rsbk_front #(
   parameter int unsigned MAX_RECORDS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rsbk_pkg::TDATA_W-1:0]        req_tdata,
   input  logic                                req_tlast,
   input  logic                                q_full,
   output logic                                q_push,
   output rsbk_pkg::queue_entry_type           q_entry
);

   localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);

   logic [CNT_W-1:0] grp_cnt_ff, grp_cnt_in;
   logic             at_capacity;

   assign req_tready  = !q_full;
   assign q_push      = req_tvalid && req_tready;
   assign at_capacity = (grp_cnt_ff == CNT_W'(MAX_RECORDS));

   // Classify the transaction: record kept or dropped, group end or not
   always_comb begin
      q_entry.rec       = rsbk_pkg::unpack_record(req_tdata);
      q_entry.group_end = req_tlast;
      q_entry.drop      = at_capacity;
   end

   // Records seen in the current group, saturating at capacity
   always_comb begin
      grp_cnt_in = grp_cnt_ff;
      if (q_push) begin
         if (req_tlast) begin
            grp_cnt_in = '0;
         end else if (!at_capacity) begin
            grp_cnt_in = grp_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_cnt_ff <= '0;
      end else begin
         grp_cnt_ff <= grp_cnt_in;
      end
   end

endmodule

// ----- src/rsbk_back.sv -----
// Back of record_sort_by_key: insertion sort chain of cells, drain and output register.
// Depends on rsbk_pkg for the record, queue entry and state types.
module rsbk_back #(
   parameter int unsigned MAX_RECORDS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  rsbk_pkg::queue_entry_type   q_entry,
   output logic                        q_pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [rsbk_pkg::TDATA_W-1:0] rsp_tdata,
   output logic                        rsp_tlast,
   output logic                        rsp_tuser
);

   localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);

   rsbk_pkg::back_state_type state_ff, state_in;
   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic                     ovf_ff, ovf_in;

   rsbk_pkg::record_type rec_ff [MAX_RECORDS];
   rsbk_pkg::record_type rec_in [MAX_RECORDS];
   logic [MAX_RECORDS-1:0] ins;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsbk_pkg::record_type rsp_rec_ff;
   logic                 rsp_last_ff;
   logic                 rsp_ovf_ff;

   logic insert_en;
   logic drain_step;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Sequencer: load records from the queue, then drain the sorted group
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      q_pop        = 1'b0;
      insert_en    = 1'b0;
      drain_step   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         rsbk_pkg::ST_LOAD: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_entry.drop) begin
                  ovf_in = 1'b1;
               end else begin
                  insert_en = 1'b1;
                  fill_in   = fill_ff + 1'b1;
               end
               if (q_entry.group_end) begin
                  state_in = rsbk_pkg::ST_DRAIN;
               end
            end
         end
         rsbk_pkg::ST_DRAIN: begin
            if (out_free) begin
               drain_step   = 1'b1;
               rsp_valid_in = 1'b1;
               if (fill_ff == CNT_W'(1)) begin
                  state_in = rsbk_pkg::ST_LOAD;
                  fill_in  = '0;
                  ovf_in   = 1'b0;
               end else begin
                  fill_in = fill_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = rsbk_pkg::ST_LOAD;
         end
      endcase
   end

   // Chain cells: a cell moves up when the new key sorts before it, drain shifts down
   for (genvar g = 0; g < MAX_RECORDS; g++) begin : g_cell
      rsbk_pkg::record_type up_src;
      rsbk_pkg::record_type down_src;

      // Cell at or past the new record's place: occupied with a greater key, or first free
      assign ins[g] = ((CNT_W'(g) < fill_ff) &&
                       (rec_ff[g].mark_key > q_entry.rec.mark_key)) ||
                      (CNT_W'(g) == fill_ff);

      if (g == 0) begin : g_first
         assign up_src = q_entry.rec;
      end else begin : g_rest
         assign up_src = ins[g-1] ? rec_ff[g-1] : q_entry.rec;
      end

      if (g == MAX_RECORDS - 1) begin : g_top
         assign down_src = rec_ff[g];
      end else begin : g_below
         assign down_src = rec_ff[g+1];
      end

      always_comb begin
         priority if (drain_step) begin
            rec_in[g] = down_src;
         end else if (insert_en && ins[g]) begin
            rec_in[g] = up_src;
         end else begin
            rec_in[g] = rec_ff[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsbk_pkg::ST_LOAD;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register, loaded from the bottom cell on each drain step
   always_ff @(posedge clock) begin
      if (drain_step) begin
         rsp_rec_ff  <= rec_ff[0];
         rsp_last_ff <= (fill_ff == CNT_W'(1));
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsbk_pkg::pack_record(rsp_rec_ff);
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   // Fill never runs past the chain length
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(MAX_RECORDS))
      else $error("sort chain fill beyond capacity");

   // A draining group always has a record left
   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rsbk_pkg::ST_DRAIN) |-> (fill_ff != '0))
      else $error("drain with empty sort chain");

   // The two lowest cells stay in ascending key order
   a_sorted_base: assert property (@(posedge clock) disable iff (reset)
      (fill_ff >= CNT_W'(2)) |-> (rec_ff[0].mark_key <= rec_ff[1].mark_key))
      else $error("sort chain out of order");

   // A held result stops the drain
   a_drain_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rsbk_pkg::ST_DRAIN && rsp_valid_ff && !rsp_tready)
      |=> (fill_ff == $past(fill_ff)))
      else $error("drain advanced while result stalled");

   // The last result of a group hands control back to loading
   a_last_ends_group: assert property (@(posedge clock) disable iff (reset)
      (drain_step && fill_ff == CNT_W'(1)) |=> (state_ff == rsbk_pkg::ST_LOAD && fill_ff == '0))
      else $error("group did not close after last result");

endmodule

// ----- src/record_sort_by_key.sv -----
// Top level of record_sort_by_key: front classifier, transaction queue and sorting back end.
// Depends on rsbk_pkg, rsbk_front, rsbk_queue and rsbk_back.
//
// Sorts one group of records, ended by the transaction with req_tlast high, into ascending
// order of the signed Q16.8 mark, stably: records with equal marks leave in arrival order.
// While loading, one record per cycle is inserted into a chain of MAX_RECORDS cells as long
// as the queue holds records. Once the group end is taken from the queue, the stored records
// of the group leave one per cycle while rsp_tready stays high; the chain accepts no new
// record during that drain, so the next group collects in the four-entry queue and
// req_tready falls when it is full. Records past MAX_RECORDS in a group are dropped and
// every result of that group carries rsp_tuser high.
module record_sort_by_key #(
   parameter int unsigned MAX_RECORDS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // roll_number[30:0], name_high[94:31], name_mid[158:95], name_low[190:159],
   // mark_key[214:191], zero pad[215]
   input  logic [rsbk_pkg::TDATA_W-1:0] req_tdata,
   input  logic                         req_tlast,   // group_end
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // out_roll_number[30:0], out_name_high[94:31], out_name_mid[158:95],
   // out_name_low[190:159], out_mark_key[214:191], zero pad[215]
   output logic [rsbk_pkg::TDATA_W-1:0] rsp_tdata,
   output logic                         rsp_tlast,   // out_last
   output logic                         rsp_tuser    // overflowed
);

   logic                      q_full;
   logic                      q_push;
   logic                      q_pop;
   logic                      q_valid;
   rsbk_pkg::queue_entry_type push_entry;
   rsbk_pkg::queue_entry_type head_entry;

   // Accept and classify
   rsbk_front #(
      .MAX_RECORDS (MAX_RECORDS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   // Decoupling queue
   rsbk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (head_entry)
   );

   // Sort and drain
   rsbk_back #(
      .MAX_RECORDS (MAX_RECORDS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (head_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
